// ===== hdl/call_state_tracker_unit_defines.svh =====
// Assertion macros used by the back end of the call state tracker RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef CALL_STATE_TRACKER_UNIT_DEFINES_SVH
`define CALL_STATE_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CST_ASSERT_SAME(lbl, ante, cons, msg)
`define CST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/cst_pkg.sv =====
// Types, codes and constants of the call state tracker.
// Used by every module of the block; depends on nothing.
package cst_pkg;

	localparam int CMD_W = 4;
	localparam int CODE_W = 3;
	localparam int TIMER_W = 16;
	localparam int MS_W = 10;
	localparam int SEC_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int TICKS_PER_SECOND = 1000;

	localparam logic [CMD_W-1:0] CMD_TICK = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SETUP_START = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SETUP_CHANGE = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SETUP_END = 4'd3;
	localparam logic [CMD_W-1:0] CMD_AUDIO = 4'd4;
	localparam logic [CMD_W-1:0] CMD_TRANSPORT = 4'd5;
	localparam logic [CMD_W-1:0] CMD_AVAIL = 4'd6;
	localparam logic [CMD_W-1:0] CMD_ANSWER = 4'd7;
	localparam logic [CMD_W-1:0] CMD_HANGUP = 4'd8;
	localparam logic [CMD_W-1:0] CMD_DIAL = 4'd9;
	localparam logic [CMD_W-1:0] CMD_TONES = 4'd10;
	localparam logic [CMD_W-1:0] CMD_DEVICE_LOST = 4'd11;

	localparam logic [CODE_W-1:0] SETUP_INCOMING = 3'd0;
	localparam logic [CODE_W-1:0] SETUP_DIALING = 3'd1;
	localparam logic [CODE_W-1:0] SETUP_ALERTING = 3'd2;
	localparam logic [CODE_W-1:0] SETUP_ACTIVE = 3'd3;
	localparam logic [CODE_W-1:0] SETUP_DISCONNECTED = 3'd4;
	localparam logic [CODE_W-1:0] TRANSPORT_IDLE = 3'd0;
	localparam logic [CODE_W-1:0] TRANSPORT_ACTIVE = 3'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_TELEPHONY_ATTACHED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_GRACE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_DEBOUNCE = 2'd2;

	localparam logic RST_TELEPHONY_ATTACHED = 1'b1;
	localparam logic [TIMER_W-1:0] RST_SETTLE_GRACE = 16'd1500;
	localparam logic [TIMER_W-1:0] RST_AUDIO_DEBOUNCE = 16'd1000;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_RINGING = 3'd1,
		PH_DIALING = 3'd2,
		PH_ALERTING = 3'd3,
		PH_ACTIVE = 3'd4
	} cst_phase_t;

	typedef enum logic [2:0] {
		REQ_NONE = 3'd0,
		REQ_ANSWER = 3'd1,
		REQ_HANGUP_ALL = 3'd2,
		REQ_DIAL = 3'd3,
		REQ_TONES = 3'd4
	} cst_req_t;

	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_TICK = 4'd1,
		OP_SETUP_START = 4'd2,
		OP_SETUP_CHANGE = 4'd3,
		OP_SETUP_END = 4'd4,
		OP_AUDIO = 4'd5,
		OP_TRANSPORT = 4'd6,
		OP_AVAIL = 4'd7,
		OP_ANSWER = 4'd8,
		OP_HANGUP = 4'd9,
		OP_DIAL = 4'd10,
		OP_TONES = 4'd11,
		OP_DEVICE_LOST = 4'd12
	} cst_op_t;

	typedef struct packed {
		cst_op_t op;
		logic [CODE_W-1:0] code;
		logic flag;
		logic empty;
	} cst_item_t;

	typedef struct packed {
		logic telephony_attached;
		logic [TIMER_W-1:0] settle_grace_ms;
		logic [TIMER_W-1:0] audio_debounce_ms;
	} cst_cfg_t;

endpackage

// ===== hdl/call_state_tracker_unit.sv =====
// Call state tracker top level: configuration registers, front end, queue, back end.
// An item taken is written into the queue, and its result is registered in the back end when it is popped.
// Throughput: one item per cycle while the output is not stalled; the back end updates the call state per item.
// The queue lets the input side keep taking items while a result waits to be taken.
// Reset clears all call state and returns the registers to attached, 1500 and 1000 ticks.
module call_state_tracker_unit #(
	parameter int TICKS_PER_SECOND = cst_pkg::TICKS_PER_SECOND,
	parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_en,
	input logic [cst_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cst_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [cst_pkg::CMD_W-1:0] command,
	input logic [cst_pkg::CODE_W-1:0] phase_code,
	input logic flag_value,
	input logic text_empty,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] call_phase,
	output logic [cst_pkg::SEC_W-1:0] call_seconds,
	output logic accepted,
	output logic [2:0] request,
	output logic phase_changed,
	output logic avail_changed
);

	cst_pkg::cst_cfg_t cfg_q;
	cst_pkg::cst_item_t front_item, queue_item;
	logic push, pop, queue_full, queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.telephony_attached <= cst_pkg::RST_TELEPHONY_ATTACHED;
			cfg_q.settle_grace_ms <= cst_pkg::RST_SETTLE_GRACE;
			cfg_q.audio_debounce_ms <= cst_pkg::RST_AUDIO_DEBOUNCE;
		end else if (cfg_write_en) begin
			case (cfg_index)
				cst_pkg::CFG_TELEPHONY_ATTACHED: cfg_q.telephony_attached <= cfg_data[0];
				cst_pkg::CFG_SETTLE_GRACE: cfg_q.settle_grace_ms <= cfg_data;
				cst_pkg::CFG_AUDIO_DEBOUNCE: cfg_q.audio_debounce_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cst_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.phase_code(phase_code),
		.flag_value(flag_value),
		.text_empty(text_empty),
		.queue_full(queue_full),
		.push(push),
		.item(front_item)
	);

	cst_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(front_item),
		.pop(pop),
		.rd_item(queue_item),
		.full(queue_full),
		.empty(queue_empty)
	);

	cst_back #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(queue_item),
		.queue_empty(queue_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.call_phase(call_phase),
		.call_seconds(call_seconds),
		.accepted(accepted),
		.request(request),
		.phase_changed(phase_changed),
		.avail_changed(avail_changed)
	);

endmodule

// ===== hdl/cst_front.sv =====
// Front end of the call state tracker: input handshake and command decode.
// Depends on cst_pkg; feeds the item queue.
module cst_front (
	input logic in_valid,
	output logic in_stall,
	input logic [cst_pkg::CMD_W-1:0] command,
	input logic [cst_pkg::CODE_W-1:0] phase_code,
	input logic flag_value,
	input logic text_empty,
	input logic queue_full,
	output logic push,
	output cst_pkg::cst_item_t item
);

	cst_pkg::cst_op_t op;

	always_comb begin
		case (command)
			cst_pkg::CMD_TICK: op = cst_pkg::OP_TICK;
			cst_pkg::CMD_SETUP_START: op = cst_pkg::OP_SETUP_START;
			cst_pkg::CMD_SETUP_CHANGE: op = cst_pkg::OP_SETUP_CHANGE;
			cst_pkg::CMD_SETUP_END: op = cst_pkg::OP_SETUP_END;
			cst_pkg::CMD_AUDIO: op = cst_pkg::OP_AUDIO;
			cst_pkg::CMD_TRANSPORT: op = cst_pkg::OP_TRANSPORT;
			cst_pkg::CMD_AVAIL: op = cst_pkg::OP_AVAIL;
			cst_pkg::CMD_ANSWER: op = cst_pkg::OP_ANSWER;
			cst_pkg::CMD_HANGUP: op = cst_pkg::OP_HANGUP;
			cst_pkg::CMD_DIAL: op = cst_pkg::OP_DIAL;
			cst_pkg::CMD_TONES: op = cst_pkg::OP_TONES;
			cst_pkg::CMD_DEVICE_LOST: op = cst_pkg::OP_DEVICE_LOST;
			default: op = cst_pkg::OP_NONE;
		endcase
	end

	assign in_stall = queue_full;
	assign push = in_valid && !queue_full;
	assign item.op = op;
	assign item.code = phase_code;
	assign item.flag = flag_value;
	assign item.empty = text_empty;

endmodule

// ===== hdl/cst_queue.sv =====
// Short item queue between the front end and the back end.
// Depends on cst_pkg for the item type.
module cst_queue #(
	parameter int DEPTH = cst_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cst_pkg::cst_item_t wr_item,
	input logic pop,
	output cst_pkg::cst_item_t rd_item,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	cst_pkg::cst_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = count_q == FULL_COUNT;
	assign empty = count_q == '0;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/cst_back.sv =====
// Back end of the call state tracker: call state update and result register.
// Depends on cst_pkg and the assertion macros in call_state_tracker_unit_defines.svh.
`include "call_state_tracker_unit_defines.svh"

module cst_back #(
	parameter int TICKS_PER_SECOND = cst_pkg::TICKS_PER_SECOND
) (
	input logic clk,
	input logic arst_n,
	input cst_pkg::cst_cfg_t cfg,
	input cst_pkg::cst_item_t item,
	input logic queue_empty,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] call_phase,
	output logic [cst_pkg::SEC_W-1:0] call_seconds,
	output logic accepted,
	output logic [2:0] request,
	output logic phase_changed,
	output logic avail_changed
);

	localparam logic [cst_pkg::MS_W-1:0] TPS_TICKS = TICKS_PER_SECOND[cst_pkg::MS_W-1:0];

	cst_pkg::cst_phase_t phase_q, phase_n;
	logic settling_q, settling_n;
	logic [cst_pkg::TIMER_W-1:0] settle_left_q, settle_left_n;
	logic audio_up_q, audio_up_n;
	logic deb_run_q, deb_run_n;
	logic [cst_pkg::TIMER_W-1:0] deb_left_q, deb_left_n;
	logic avail_q, avail_n;
	logic [cst_pkg::MS_W-1:0] ms_q, ms_n, ms_inc;
	logic [cst_pkg::SEC_W-1:0] seconds_q, seconds_n;
	logic acc_n, avail_chg_n;
	cst_pkg::cst_req_t req_n;
	logic real_backend, in_setup;

	logic out_valid_q;
	cst_pkg::cst_phase_t out_phase_q;
	logic accepted_q, phase_changed_q, avail_changed_q;
	cst_pkg::cst_req_t request_q;

	assign pop = !queue_empty && (!out_valid_q || !out_stall);
	assign real_backend = cfg.telephony_attached && avail_q;
	assign in_setup = phase_q == cst_pkg::PH_RINGING || phase_q == cst_pkg::PH_DIALING ||
		phase_q == cst_pkg::PH_ALERTING;
	assign ms_inc = ms_q + 1'b1;

	always_comb begin
		phase_n = phase_q;
		settling_n = settling_q;
		settle_left_n = settle_left_q;
		audio_up_n = audio_up_q;
		deb_run_n = deb_run_q;
		deb_left_n = deb_left_q;
		avail_n = avail_q;
		ms_n = ms_q;
		seconds_n = seconds_q;
		acc_n = 1'b0;
		req_n = cst_pkg::REQ_NONE;
		avail_chg_n = 1'b0;
		case (item.op)
			cst_pkg::OP_TICK: begin
				if (settling_q) begin
					if (settle_left_q <= 16'd1) begin
						settle_left_n = '0;
						settling_n = 1'b0;
						phase_n = cst_pkg::PH_IDLE;
					end else begin
						settle_left_n = settle_left_q - 1'b1;
					end
				end
				if (deb_run_q) begin
					if (deb_left_q <= 16'd1) begin
						deb_left_n = '0;
						deb_run_n = 1'b0;
						if (phase_n == cst_pkg::PH_ACTIVE && !audio_up_q) begin
							phase_n = cst_pkg::PH_IDLE;
						end
					end else begin
						deb_left_n = deb_left_q - 1'b1;
					end
				end
				if (phase_n == cst_pkg::PH_ACTIVE) begin
					if (ms_inc >= TPS_TICKS) begin
						ms_n = '0;
						if (seconds_q != '1) begin
							seconds_n = seconds_q + 1'b1;
						end
					end else begin
						ms_n = ms_inc;
					end
				end
			end
			cst_pkg::OP_SETUP_START: begin
				if (phase_q != cst_pkg::PH_ACTIVE) begin
					if (item.code == cst_pkg::SETUP_INCOMING) begin
						phase_n = cst_pkg::PH_RINGING;
					end else if (item.code == cst_pkg::SETUP_DIALING) begin
						phase_n = cst_pkg::PH_DIALING;
					end else if (item.code == cst_pkg::SETUP_ALERTING) begin
						phase_n = cst_pkg::PH_ALERTING;
					end
				end
			end
			cst_pkg::OP_SETUP_CHANGE: begin
				if (in_setup) begin
					if (item.code == cst_pkg::SETUP_ALERTING) begin
						phase_n = cst_pkg::PH_ALERTING;
					end else if (item.code == cst_pkg::SETUP_ACTIVE) begin
						settling_n = 1'b0;
						phase_n = cst_pkg::PH_ACTIVE;
					end else if (item.code == cst_pkg::SETUP_DISCONNECTED) begin
						settling_n = 1'b0;
						phase_n = cst_pkg::PH_IDLE;
					end
				end
			end
			cst_pkg::OP_SETUP_END: begin
				if (in_setup) begin
					if (audio_up_q) begin
						phase_n = cst_pkg::PH_ACTIVE;
					end else begin
						settling_n = 1'b1;
						settle_left_n = cfg.settle_grace_ms;
					end
				end
			end
			cst_pkg::OP_AUDIO: begin
				audio_up_n = item.flag;
				if (item.flag) begin
					deb_run_n = 1'b0;
					if (settling_q) begin
						settling_n = 1'b0;
						phase_n = cst_pkg::PH_ACTIVE;
					end else if (phase_q == cst_pkg::PH_IDLE && avail_q) begin
						phase_n = cst_pkg::PH_ACTIVE;
					end
				end else if (phase_q == cst_pkg::PH_ACTIVE) begin
					deb_run_n = 1'b1;
					deb_left_n = cfg.audio_debounce_ms;
				end
			end
			cst_pkg::OP_TRANSPORT: begin
				if (item.code == cst_pkg::TRANSPORT_ACTIVE && settling_q) begin
					settling_n = 1'b0;
					phase_n = cst_pkg::PH_ACTIVE;
				end else if (item.code == cst_pkg::TRANSPORT_IDLE &&
					phase_q == cst_pkg::PH_ACTIVE && !audio_up_q) begin
					deb_run_n = 1'b0;
					phase_n = cst_pkg::PH_IDLE;
				end
			end
			cst_pkg::OP_AVAIL: begin
				if (item.flag != avail_q) begin
					avail_n = item.flag;
					avail_chg_n = 1'b1;
					if (!item.flag) begin
						settling_n = 1'b0;
						deb_run_n = 1'b0;
						phase_n = cst_pkg::PH_IDLE;
					end
				end
			end
			cst_pkg::OP_ANSWER: begin
				if (phase_q == cst_pkg::PH_RINGING) begin
					acc_n = 1'b1;
					if (real_backend) begin
						req_n = cst_pkg::REQ_ANSWER;
					end else begin
						phase_n = cst_pkg::PH_ACTIVE;
					end
				end
			end
			cst_pkg::OP_HANGUP: begin
				if (phase_q != cst_pkg::PH_IDLE) begin
					acc_n = 1'b1;
					if (real_backend) begin
						req_n = cst_pkg::REQ_HANGUP_ALL;
					end else begin
						phase_n = cst_pkg::PH_IDLE;
					end
				end
			end
			cst_pkg::OP_DIAL: begin
				if (phase_q == cst_pkg::PH_IDLE && !item.empty) begin
					if (real_backend) begin
						acc_n = 1'b1;
						req_n = cst_pkg::REQ_DIAL;
					end else if (!cfg.telephony_attached) begin
						acc_n = 1'b1;
						phase_n = cst_pkg::PH_DIALING;
					end
				end
			end
			cst_pkg::OP_TONES: begin
				if (phase_q == cst_pkg::PH_ACTIVE && !item.empty) begin
					if (real_backend) begin
						acc_n = 1'b1;
						req_n = cst_pkg::REQ_TONES;
					end else if (!cfg.telephony_attached) begin
						acc_n = 1'b1;
					end
				end
			end
			cst_pkg::OP_DEVICE_LOST: begin
				phase_n = cst_pkg::PH_IDLE;
			end
			default: begin
			end
		endcase
		// Entering the active phase restarts the call timer.
		if (phase_n == cst_pkg::PH_ACTIVE && phase_q != cst_pkg::PH_ACTIVE) begin
			seconds_n = '0;
			ms_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cst_pkg::PH_IDLE;
			settling_q <= 1'b0;
			settle_left_q <= '0;
			audio_up_q <= 1'b0;
			deb_run_q <= 1'b0;
			deb_left_q <= '0;
			avail_q <= 1'b0;
			ms_q <= '0;
			seconds_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				settling_q <= settling_n;
				settle_left_q <= settle_left_n;
				audio_up_q <= audio_up_n;
				deb_run_q <= deb_run_n;
				deb_left_q <= deb_left_n;
				avail_q <= avail_n;
				ms_q <= ms_n;
				seconds_q <= seconds_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_phase_q <= phase_n;
			accepted_q <= acc_n;
			request_q <= req_n;
			phase_changed_q <= phase_n != phase_q;
			avail_changed_q <= avail_chg_n;
		end
	end

	assign out_valid = out_valid_q;
	assign call_phase = out_phase_q;
	assign call_seconds = seconds_q;
	assign accepted = accepted_q;
	assign request = request_q;
	assign phase_changed = phase_changed_q;
	assign avail_changed = avail_changed_q;

	`CST_ASSERT_NEXT(a_pop_fills_output, pop, out_valid_q, "Taken item left no result.")
	`CST_ASSERT_NEXT(a_active_clears_timer, pop && phase_n == cst_pkg::PH_ACTIVE && phase_q != cst_pkg::PH_ACTIVE, seconds_q == '0 && ms_q == '0, "Call timer not cleared on entering active.")
	`CST_ASSERT_NEXT(a_changed_matches_phase, pop, phase_changed_q == (phase_q != $past(phase_q)), "Phase change flag disagrees with the phase register.")
	`CST_ASSERT_SAME(a_avail_only_by_avail_item, pop && item.op != cst_pkg::OP_AVAIL, avail_n == avail_q && !avail_chg_n, "Availability moved on a non-availability item.")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for call_state_tracker_unit, the call state tracker top level.
// Depends on cst_pkg and the RTL only. It predicts every result in place and compares
// each result with the oldest outstanding one while both sides idle and stall at random.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cst_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd12;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 4'd15;
	localparam logic [CODE_W-1:0] CODE_LAST = 3'd7;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		cst_phase_t phase;
		logic [SEC_W-1:0] seconds;
		logic taken;
		cst_req_t req;
		logic phase_chg;
		logic avail_chg;
	} call_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] command = '0;
	logic [CODE_W-1:0] phase_code = '0;
	logic flag_value = 1'b0;
	logic text_empty = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] call_phase;
	logic [SEC_W-1:0] call_seconds;
	logic accepted;
	logic [2:0] request;
	logic phase_changed;
	logic avail_changed;

	// Predicted copy of the configuration and the call state.
	logic tel_attached;
	logic [TIMER_W-1:0] settle_len;
	logic [TIMER_W-1:0] debounce_len;
	cst_phase_t cur_phase;
	logic settle_on;
	logic [TIMER_W-1:0] settle_cnt;
	logic audio_on;
	logic deb_on;
	logic [TIMER_W-1:0] deb_cnt;
	logic avail;
	logic [MS_W-1:0] ms_cnt;
	logic [SEC_W-1:0] sec_cnt;

	call_result_t expected_results[$];
	int errors = 0;
	int gap_pct = 20;
	int stall_pct = 20;
	bit hold_off_req = 1'b0;
	int quiet_cycles = 0;

	call_state_tracker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.phase_code(phase_code),
		.flag_value(flag_value),
		.text_empty(text_empty),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.call_phase(call_phase),
		.call_seconds(call_seconds),
		.accepted(accepted),
		.request(request),
		.phase_changed(phase_changed),
		.avail_changed(avail_changed)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [TIMER_W-1:0] pick_timer();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return TIMER_W'($urandom_range(1, 8));
		if (r < 80)
			return '0;
		if (r < 90)
			return TIMER_W'($urandom_range(9, 40));
		return '1;
	endfunction

	function automatic void enter_phase(cst_phase_t p);
		if (p == cur_phase)
			return;
		cur_phase = p;
		if (p == PH_ACTIVE) begin
			sec_cnt = '0;
			ms_cnt = '0;
		end
	endfunction

	function automatic logic in_setup();
		return cur_phase == PH_RINGING || cur_phase == PH_DIALING ||
			cur_phase == PH_ALERTING;
	endfunction

	function automatic void advance_ms();
		if (settle_on) begin
			if (settle_cnt <= 1) begin
				settle_cnt = '0;
				settle_on = 1'b0;
				enter_phase(PH_IDLE);
			end else
				settle_cnt--;
		end
		if (deb_on) begin
			if (deb_cnt <= 1) begin
				deb_cnt = '0;
				deb_on = 1'b0;
				if (cur_phase == PH_ACTIVE && !audio_on)
					enter_phase(PH_IDLE);
			end else
				deb_cnt--;
		end
		if (cur_phase == PH_ACTIVE) begin
			ms_cnt = ms_cnt + 1'b1;
			if (ms_cnt >= TICKS_PER_SECOND) begin
				ms_cnt = '0;
				if (sec_cnt != '1)
					sec_cnt++;
			end
		end
	endfunction

	function automatic call_result_t predict_call(logic [CMD_W-1:0] cmd,
			logic [CODE_W-1:0] code, logic flag, logic empty);
		call_result_t r;
		cst_phase_t prior;
		logic usable;
		prior = cur_phase;
		usable = tel_attached && avail;
		r.taken = 1'b0;
		r.req = REQ_NONE;
		r.avail_chg = 1'b0;
		case (cmd)
			CMD_TICK: advance_ms();
			CMD_SETUP_START: begin
				if (cur_phase != PH_ACTIVE) begin
					if (code == SETUP_INCOMING)
						enter_phase(PH_RINGING);
					else if (code == SETUP_DIALING)
						enter_phase(PH_DIALING);
					else if (code == SETUP_ALERTING)
						enter_phase(PH_ALERTING);
				end
			end
			CMD_SETUP_CHANGE: begin
				if (in_setup()) begin
					if (code == SETUP_ALERTING)
						enter_phase(PH_ALERTING);
					else if (code == SETUP_ACTIVE) begin
						settle_on = 1'b0;
						enter_phase(PH_ACTIVE);
					end else if (code == SETUP_DISCONNECTED) begin
						settle_on = 1'b0;
						enter_phase(PH_IDLE);
					end
				end
			end
			CMD_SETUP_END: begin
				if (in_setup()) begin
					if (audio_on)
						enter_phase(PH_ACTIVE);
					else begin
						settle_on = 1'b1;
						settle_cnt = settle_len;
					end
				end
			end
			CMD_AUDIO: begin
				audio_on = flag;
				if (flag) begin
					deb_on = 1'b0;
					if (settle_on) begin
						settle_on = 1'b0;
						enter_phase(PH_ACTIVE);
					end else if (cur_phase == PH_IDLE && avail)
						enter_phase(PH_ACTIVE);
				end else if (cur_phase == PH_ACTIVE) begin
					deb_on = 1'b1;
					deb_cnt = debounce_len;
				end
			end
			CMD_TRANSPORT: begin
				if (code == TRANSPORT_ACTIVE && settle_on) begin
					settle_on = 1'b0;
					enter_phase(PH_ACTIVE);
				end else if (code == TRANSPORT_IDLE && cur_phase == PH_ACTIVE && !audio_on) begin
					deb_on = 1'b0;
					enter_phase(PH_IDLE);
				end
			end
			CMD_AVAIL: begin
				if (flag != avail) begin
					avail = flag;
					r.avail_chg = 1'b1;
					if (!flag) begin
						settle_on = 1'b0;
						deb_on = 1'b0;
						enter_phase(PH_IDLE);
					end
				end
			end
			CMD_ANSWER: begin
				if (cur_phase == PH_RINGING) begin
					r.taken = 1'b1;
					if (usable)
						r.req = REQ_ANSWER;
					else
						enter_phase(PH_ACTIVE);
				end
			end
			CMD_HANGUP: begin
				if (cur_phase != PH_IDLE) begin
					r.taken = 1'b1;
					if (usable)
						r.req = REQ_HANGUP_ALL;
					else
						enter_phase(PH_IDLE);
				end
			end
			CMD_DIAL: begin
				if (cur_phase == PH_IDLE && !empty) begin
					if (usable) begin
						r.taken = 1'b1;
						r.req = REQ_DIAL;
					end else if (!tel_attached) begin
						r.taken = 1'b1;
						enter_phase(PH_DIALING);
					end
				end
			end
			CMD_TONES: begin
				if (cur_phase == PH_ACTIVE && !empty) begin
					if (usable) begin
						r.taken = 1'b1;
						r.req = REQ_TONES;
					end else if (!tel_attached)
						r.taken = 1'b1;
				end
			end
			CMD_DEVICE_LOST: enter_phase(PH_IDLE);
			default: ;
		endcase
		r.phase = cur_phase;
		r.seconds = sec_cnt;
		r.phase_chg = cur_phase != prior;
		return r;
	endfunction

	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
			input logic flag, input logic empty);
		int gap;
		gap = 0;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct)
			gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		phase_code <= code;
		flag_value <= flag;
		text_empty <= empty;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_call(cmd, code, flag, empty));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_event(CMD_TICK, CODE_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_TELEPHONY_ATTACHED: tel_attached = value[0];
			CFG_SETTLE_GRACE: settle_len = value;
			CFG_AUDIO_DEBOUNCE: debounce_len = value;
			default: ;
		endcase
	endtask

	task automatic configure(input logic attached, input logic [TIMER_W-1:0] settle,
			input logic [TIMER_W-1:0] debounce);
		wait_for_results();
		repeat (2) @(posedge clk);
		put_register(CFG_TELEPHONY_ATTACHED, {15'($urandom), attached});
		put_register(CFG_SETTLE_GRACE, settle);
		put_register(CFG_AUDIO_DEBOUNCE, debounce);
		put_register(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_write_en <= 1'b0;
	endtask

	// Picks the next event from what makes sense in the predicted phase, with some noise.
	task automatic random_event();
		int pick;
		int s;
		logic [CODE_W-1:0] code;
		logic flag;
		logic empty;
		pick = $urandom_range(99);
		s = $urandom_range(9);
		code = CODE_W'($urandom);
		flag = 1'($urandom);
		empty = $urandom_range(9) == 0;
		if (pick < 8) begin
			send_event(CMD_W'($urandom), code, flag, 1'($urandom));
			return;
		end
		if (pick < 30) begin
			send_ticks(($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5));
			return;
		end
		if (cur_phase == PH_IDLE) begin
			case (s)
				0, 1, 2: send_event(CMD_SETUP_START, CODE_W'($urandom_range(2)), flag, empty);
				3: send_event(CMD_SETUP_START, code, flag, empty);
				4, 5: send_event(CMD_DIAL, code, flag, empty);
				6: send_event(CMD_AUDIO, code, flag, empty);
				7: send_event(CMD_AVAIL, code, flag, empty);
				8: send_event(flag ? CMD_HANGUP : CMD_ANSWER, code, flag, empty);
				default: send_event(flag ? CMD_TONES : CMD_TRANSPORT, code, flag, empty);
			endcase
		end else if (cur_phase == PH_ACTIVE) begin
			case (s)
				0, 1: send_event(CMD_TONES, code, flag, empty);
				2: send_event(CMD_AUDIO, code, flag, empty);
				3: send_event(CMD_TRANSPORT, CODE_W'($urandom_range(2)), flag, empty);
				4: send_event(CMD_HANGUP, code, flag, empty);
				5: send_event(CMD_SETUP_CHANGE, code, flag, empty);
				6: send_event(CMD_AVAIL, code, flag, empty);
				7: send_event(CMD_DEVICE_LOST, code, flag, empty);
				8: send_event(CMD_SETUP_START, code, flag, empty);
				default: send_event(flag ? CMD_ANSWER : CMD_DIAL, code, flag, empty);
			endcase
		end else begin
			case (s)
				0: send_event(CMD_SETUP_CHANGE, CODE_W'($urandom_range(2, 4)), flag, empty);
				1, 2: send_event(CMD_SETUP_END, code, flag, empty);
				3: send_event(CMD_ANSWER, code, flag, empty);
				4: send_event(CMD_HANGUP, code, flag, empty);
				5: send_event(CMD_AUDIO, code, flag, empty);
				6: send_event(CMD_TRANSPORT, CODE_W'($urandom_range(2)), flag, empty);
				7: send_event(CMD_AVAIL, code, flag, empty);
				8: send_event(CMD_SETUP_START, code, flag, empty);
				default: send_event(flag ? CMD_DEVICE_LOST : CMD_SETUP_CHANGE, code, flag, empty);
			endcase
		end
	endtask

	task automatic run_random(input int n);
		repeat (n) random_event();
	endtask

	// With the registers at their reset values: a setup that the audio link confirms inside
	// the settle window, an audio drop that an idle transport ends inside the debounce time, and a second setup
	// that the transport confirms before the device is lost.
	task automatic test_reset_timers();
		gap_pct = 10;
		stall_pct = 10;
		send_event(CMD_SETUP_START, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_SETUP_END, SETUP_INCOMING, 1'b0, 1'b0);
		send_ticks($urandom_range(1, 8));
		send_event(CMD_AUDIO, SETUP_INCOMING, 1'b1, 1'b0);
		send_ticks($urandom_range(1, 8));
		send_event(CMD_AUDIO, SETUP_INCOMING, 1'b0, 1'b0);
		send_ticks($urandom_range(1, 8));
		send_event(CMD_TRANSPORT, TRANSPORT_IDLE, 1'b0, 1'b0);
		send_event(CMD_SETUP_START, SETUP_DIALING, 1'b0, 1'b0);
		send_event(CMD_SETUP_CHANGE, SETUP_ALERTING, 1'b0, 1'b0);
		send_event(CMD_SETUP_END, SETUP_ALERTING, 1'b0, 1'b0);
		send_ticks($urandom_range(1, 8));
		send_event(CMD_TRANSPORT, TRANSPORT_ACTIVE, 1'b0, 1'b0);
		send_ticks($urandom_range(1, 8));
		send_event(CMD_DEVICE_LOST, SETUP_INCOMING, 1'b0, 1'b0);
	endtask

	task automatic test_directed_cases();
		configure(1'b1, '0, 16'd2);
		gap_pct = 20;
		stall_pct = 20;
		send_event(CMD_AVAIL, SETUP_INCOMING, 1'b1, 1'b0);
		send_event(CMD_DIAL, SETUP_INCOMING, 1'b0, 1'b1);
		send_event(CMD_DIAL, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_SETUP_START, SETUP_ACTIVE, 1'b0, 1'b0);
		send_event(CMD_SETUP_START, SETUP_DIALING, 1'b0, 1'b0);
		send_event(CMD_SETUP_CHANGE, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_SETUP_CHANGE, SETUP_ALERTING, 1'b0, 1'b0);
		send_event(CMD_SETUP_END, SETUP_ALERTING, 1'b0, 1'b0);
		send_event(CMD_TICK, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_SETUP_START, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_ANSWER, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_SETUP_CHANGE, SETUP_ACTIVE, 1'b0, 1'b0);
		send_event(CMD_SETUP_START, SETUP_DIALING, 1'b0, 1'b0);
		send_event(CMD_TONES, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_HANGUP, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_AUDIO, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_TRANSPORT, CODE_LAST, 1'b1, 1'b1);
		send_event(CMD_TICK, CODE_LAST, 1'b1, 1'b1);
		send_event(CMD_TICK, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_SETUP_CHANGE, SETUP_ACTIVE, 1'b0, 1'b0);
		send_event(CMD_SPARE_LAST, CODE_LAST, 1'b1, 1'b1);
		send_event(CMD_SPARE_FIRST, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_DEVICE_LOST, SETUP_INCOMING, 1'b0, 1'b0);
		send_event(CMD_AVAIL, SETUP_INCOMING, 1'b0, 1'b0);
	endtask

	task automatic test_mock_mode();
		configure(1'b0, 16'd3, '1);
		run_random(75);
	endtask

	task automatic test_random_calls();
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(1'b1, 16'd1, 16'd1);
				1: configure(1'b1, '1, '1);
				default: configure(1'($urandom), pick_timer(), pick_timer());
			endcase
			gap_pct = ($urandom_range(3) == 0) ? 0 : 25;
			stall_pct = ($urandom_range(3) == 0) ? 0 : 25;
			run_random(60);
		end
	endtask

	task automatic test_backpressure();
		configure(1'b1, 16'd4, 16'd4);
		gap_pct = 0;
		stall_pct = 0;
		hold_off_req = 1'b1;
		run_random(60);
		gap_pct = 25;
		stall_pct = 25;
	endtask

	task automatic test_drain_pause();
		run_random(30);
		wait_for_results();
		run_random(30);
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat (pick_gap() - 1) @(posedge clk);
			end else
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		call_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no item outstanding");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (call_phase !== want.phase) begin
					$error("call_phase: expected %0d, got %0d", want.phase, call_phase);
					errors++;
				end
				if (call_seconds !== want.seconds) begin
					$error("call_seconds: expected %0d, got %0d", want.seconds, call_seconds);
					errors++;
				end
				if (accepted !== want.taken) begin
					$error("accepted: expected %0d, got %0d", want.taken, accepted);
					errors++;
				end
				if (request !== want.req) begin
					$error("request: expected %0d, got %0d", want.req, request);
					errors++;
				end
				if (phase_changed !== want.phase_chg) begin
					$error("phase_changed: expected %0d, got %0d", want.phase_chg,
						phase_changed);
					errors++;
				end
				if (avail_changed !== want.avail_chg) begin
					$error("avail_changed: expected %0d, got %0d", want.avail_chg,
						avail_changed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		tel_attached = RST_TELEPHONY_ATTACHED;
		settle_len = RST_SETTLE_GRACE;
		debounce_len = RST_AUDIO_DEBOUNCE;
		cur_phase = PH_IDLE;
		settle_on = 1'b0;
		settle_cnt = '0;
		audio_on = 1'b0;
		deb_on = 1'b0;
		deb_cnt = '0;
		avail = 1'b0;
		ms_cnt = '0;
		sec_cnt = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_timers();
		test_directed_cases();
		test_mock_mode();
		test_random_calls();
		test_backpressure();
		test_drain_pause();
		wait_for_results();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
